// ----- rtl/ffa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types, command and status codes for the free-list allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned MaxFreeBlocks = 16;
  localparam int unsigned HeaderBytes   = 16;
  localparam int unsigned SizeBits      = 24;

  localparam logic [1:0] CmdAlloc  = 2'd0;
  localparam logic [1:0] CmdFree   = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [1:0] StDone   = 2'd0;
  localparam logic [1:0] StNoFit  = 2'd1;
  localparam logic [1:0] StFull   = 2'd2;

  localparam logic [0:0] CfgBase = 1'd0;
  localparam logic [0:0] CfgSize = 1'd1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [24:0] req_size;
    logic [3:0]  align_log2;
    logic [31:0] address;
    logic [24:0] freed_size;
    logic [12:0] freed_adjust;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] user_address;
    logic [24:0] granted_size;
    logic [12:0] granted_adjust;
  } rsp_t;

  // one table entry; bytes width covers 2^32 for the widest size setting
  typedef struct packed {
    logic        vld;
    logic [31:0] start;
    logic [32:0] bytes;
  } blk_t;

  // per-cell shift controls from the sequencer
  typedef struct packed {
    logic shift_dn;   // entry i takes entry i+1
    logic shift_up;   // entry i takes entry i-1
    logic wr;         // write wr_blk at wr_idx
  } cell_ctl_t;

endpackage

// ----- rtl/first_fit_free_list_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// first-fit allocator over an address-sorted chain of free-block cells
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid_i/req_ready_o/req_i) takes one command beat:
//   allocate, free or clear. rsp channel (rsp_valid_o/rsp_ready_i/rsp_o)
//   returns exactly one beat per command.
//   cfg_we_i/cfg_idx_i/cfg_data_i write region base and size; they take
//   effect at the next clear command; reset restores the default region.
// operation:
//   one command at a time. a sequencer scans the cell chain one entry per
//   cycle (allocate: to find the first fit, free: to find the insert point),
//   then any removal or insertion ripples through the chain one cell per cycle.
//   clear and unknown commands go straight to the response; the next beat
//   is taken in the cycle after the response is loaded.
// throughput:
//   the next beat is taken once the previous response is in the output
//   register; a stalled receiver holds rsp_o and blocks only the next
//   command's response, not its acceptance.
// reset:
//   the table holds one block covering the reset region, count is one.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_core #(
  parameter int unsigned MAX_FREE_BLOCKS = ffa_pkg::MaxFreeBlocks,
  parameter int unsigned HEADER_BYTES    = ffa_pkg::HeaderBytes,
  parameter int unsigned SIZE_BITS       = ffa_pkg::SizeBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  ffa_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output ffa_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);
  localparam int unsigned IW = $clog2(MAX_FREE_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_FREE_BLOCKS + 1);
  localparam logic [32:0] Limit = 33'(64'd1 << SIZE_BITS);
  localparam logic [32:0] Hdr   = 33'(HEADER_BYTES);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_FREE_BLOCKS);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHDN, S_SHUP, S_RESP
  } state_e;

  state_e        state_q;
  logic [31:0]   base_q;
  logic [24:0]   size_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] idx_q;   // scan position
  logic [CW-1:0] pos_q;   // ripple position
  logic [CW-1:0] tgt_q;   // entry where the ripple stops
  ffa_pkg::req_t req_q;
  ffa_pkg::rsp_t rsp_q;
  ffa_pkg::rsp_t res_q;   // response being built
  logic          rsp_vld_q;
  logic [12:0]   align_q;
  logic          clear_q;
  ffa_pkg::blk_t wr_blk_q;
  logic [IW-1:0] wr_idx_q;
  logic          wr_q;

  ffa_pkg::blk_t blk [MAX_FREE_BLOCKS];
  ffa_pkg::blk_t init_blk;
  ffa_pkg::cell_ctl_t ctl;

  // clamped region for a rebuild
  logic [32:0] room, reg_sz;
  always_comb begin
    room   = 33'h1_0000_0000 - {1'b0, base_q};
    reg_sz = {8'd0, size_q};
    if (reg_sz < 33'd64) reg_sz = 33'd64;
    if (reg_sz > Limit) reg_sz = Limit;
    if (reg_sz > room) reg_sz = room;
  end

  // the scanned entry and its predecessor, muxed by the scan position
  ffa_pkg::blk_t cur, prv;
  logic [IW-1:0] cur_i;
  assign cur_i = idx_q[IW-1:0];
  always_comb begin
    cur = blk[cur_i];
    prv = (idx_q == '0) ? '0 : blk[IW'(idx_q - 1'b1)];
  end

  // alignment adjustment for the scanned entry
  logic [12:0] a_mask, adj0;
  logic [13:0] adj;
  logic [33:0] total;
  always_comb begin
    a_mask = align_q - 13'd1;
    adj0   = (13'd0 - cur.start[12:0]) & a_mask;
    adj    = {1'b0, adj0};
    if ({20'd0, adj0} < Hdr) begin
      adj = {1'b0, adj0} +
            (((14'(HEADER_BYTES) - {1'b0, adj0} + {1'b0, a_mask}) & ~{1'b0, a_mask}));
    end
    total = {9'd0, req_q.req_size} + {20'd0, adj};
  end

  // free block geometry
  logic [32:0] f_size, f_bs, f_end;
  logic        f_skip;
  always_comb begin
    f_size = {8'd0, req_q.freed_size};
    if (f_size > Limit) f_size = Limit;
    f_bs   = {1'b0, req_q.address} - {20'd0, req_q.freed_adjust};
    f_end  = f_bs + f_size;
    f_skip = (f_size == '0) || ({20'd0, req_q.freed_adjust} > {1'b0, req_q.address})
             || (f_end > 33'h1_0000_0000);
  end

  // merge decisions at insert point k = idx_q (cur is entry k)
  logic k_end, mp, mn;
  logic [33:0] mrg;
  always_comb begin
    k_end = (idx_q >= cnt_q);
    mp  = (idx_q != '0) && ({1'b0, prv.start} + prv.bytes == f_bs) &&
          ({1'b0, prv.bytes} + {1'b0, f_size} <= {1'b0, Limit});
    mrg = {1'b0, f_size} + {1'b0, cur.bytes} + (mp ? {1'b0, prv.bytes} : 34'd0);
    mn  = !k_end && ({1'b0, cur.start} == f_end) && (mrg <= {1'b0, Limit});
  end

  assign init_blk = '{vld: 1'b1, start: base_q, bytes: reg_sz};
  assign ctl = '{shift_dn: state_q == S_SHDN, shift_up: state_q == S_SHUP, wr: wr_q};

  for (genvar g = 0; g < MAX_FREE_BLOCKS; g++) begin : g_cell
    ffa_pkg::blk_t lo, hi, ini;
    logic          wr_sel, sh_sel;
    assign lo  = (g == 0) ? '0 : blk[(g == 0) ? 0 : g - 1];
    assign hi  = (g == MAX_FREE_BLOCKS - 1) ? '0 : blk[(g == MAX_FREE_BLOCKS - 1) ? g : g + 1];
    assign ini = (g == 0) ? init_blk : '0;
    // a write and a shift may land on different cells in the same cycle
    assign wr_sel = (wr_idx_q == IW'(g));
    assign sh_sel = (pos_q[IW-1:0] == IW'(g));
    ffa_cell u_cell (
      .clk_i, .rst_ni, .clear_i(clear_q), .init_i(ini), .ctl_i(ctl),
      .wr_sel_i(wr_sel), .sh_sel_i(sh_sel), .wr_blk_i(wr_blk_q),
      .lo_i(lo), .hi_i(hi), .blk_o(blk[g])
    );
  end

  assign req_ready_o = (state_q == S_IDLE) && !clear_q && !wr_q;
  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      base_q    <= '0;
      size_q    <= 25'h100_0000;
      cnt_q     <= CW'(1);
      idx_q     <= '0;
      pos_q     <= '0;
      tgt_q     <= '0;
      rsp_vld_q <= 1'b0;
      clear_q   <= 1'b1;
      wr_q      <= 1'b0;
    end else begin
      clear_q <= 1'b0;
      wr_q    <= 1'b0;
      if (state_q == S_RESP && (!rsp_vld_q || rsp_ready_i)) rsp_vld_q <= 1'b1;
      else if (rsp_ready_i) rsp_vld_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == ffa_pkg::CfgBase) base_q <= cfg_data_i;
        else size_q <= cfg_data_i[24:0];
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && req_ready_o) begin
            req_q   <= req_i;
            align_q <= 13'd1 << ((req_i.align_log2 > 4'd12) ? 4'd12 : req_i.align_log2);
            idx_q   <= '0;
            res_q   <= '0;
            case (req_i.cmd)
              ffa_pkg::CmdAlloc, ffa_pkg::CmdFree: state_q <= S_SCAN;
              ffa_pkg::CmdClear: begin
                clear_q <= 1'b1;
                cnt_q   <= CW'(1);
                state_q <= S_RESP;
              end
              default: state_q <= S_RESP;
            endcase
          end
        end
        S_SCAN: begin
          if (req_q.cmd == ffa_pkg::CmdAlloc) begin
            if (idx_q >= cnt_q) begin
              res_q.status <= ffa_pkg::StNoFit;
              state_q      <= S_RESP;
            end else if ({1'b0, cur.bytes} >= total) begin
              res_q.user_address   <= cur.start + {18'd0, adj};
              res_q.granted_adjust <= adj[12:0];
              if ({1'b0, cur.bytes} - total <= {1'b0, Hdr}) begin
                res_q.granted_size <= cur.bytes[24:0];
                pos_q   <= idx_q;
                tgt_q   <= cnt_q - 1'b1;
                cnt_q   <= cnt_q - 1'b1;
                state_q <= S_SHDN;
              end else begin
                res_q.granted_size <= total[24:0];
                wr_q     <= 1'b1;
                wr_idx_q <= cur_i;
                wr_blk_q <= '{vld: 1'b1, start: cur.start + total[31:0],
                              bytes: cur.bytes - total[32:0]};
                state_q  <= S_RESP;
              end
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end else if (f_skip) begin
            state_q <= S_RESP;
          end else if (!k_end && {1'b0, cur.start} < f_end) begin
            idx_q <= idx_q + 1'b1;
          end else if (mp && mn) begin
            wr_q     <= 1'b1;
            wr_idx_q <= cur_i - 1'b1;
            wr_blk_q <= '{vld: 1'b1, start: prv.start, bytes: mrg[32:0]};
            pos_q    <= idx_q;
            tgt_q    <= cnt_q - 1'b1;
            cnt_q    <= cnt_q - 1'b1;
            state_q  <= S_SHDN;
          end else if (mp) begin
            wr_q     <= 1'b1;
            wr_idx_q <= cur_i - 1'b1;
            wr_blk_q <= '{vld: 1'b1, start: prv.start, bytes: prv.bytes + f_size};
            state_q  <= S_RESP;
          end else if (mn) begin
            wr_q     <= 1'b1;
            wr_idx_q <= cur_i;
            wr_blk_q <= '{vld: 1'b1, start: f_bs[31:0], bytes: cur.bytes + f_size};
            state_q  <= S_RESP;
          end else if (cnt_q >= MaxCnt) begin
            res_q.status <= ffa_pkg::StFull;
            state_q      <= S_RESP;
          end else begin
            // open a hole at k by rippling from the top down
            wr_blk_q <= '{vld: 1'b1, start: f_bs[31:0], bytes: f_size};
            wr_idx_q <= cur_i;
            pos_q    <= cnt_q;
            tgt_q    <= idx_q;
            cnt_q    <= cnt_q + 1'b1;
            state_q  <= S_SHUP;
          end
        end
        S_SHDN: begin
          // entry pos takes pos+1; last cell takes zero from its high side
          pos_q <= pos_q + 1'b1;
          if (pos_q >= tgt_q) state_q <= S_RESP;
        end
        S_SHUP: begin
          if (pos_q == tgt_q) begin
            wr_q    <= 1'b1;
            state_q <= S_RESP;
          end else begin
            pos_q <= pos_q - 1'b1;
          end
        end
        S_RESP: begin
          if (!rsp_vld_q || rsp_ready_i) begin
            rsp_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // a response beat only leaves with a legal status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.status == ffa_pkg::StDone || rsp_o.status == ffa_pkg::StNoFit ||
                     rsp_o.status == ffa_pkg::StFull))
    else $error("bad status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("block count out of range");

  // a held response stays put while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> ($stable(rsp_o) && rsp_valid_o))
    else $error("response changed while stalled");

  // no new command while the table is rippling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHDN || state_q == S_SHUP) |-> !req_ready_o)
    else $error("ready during ripple");
endmodule

// ----- rtl/ffa_cell.sv -----
// ----------------------------------------------------------------------------
// ffa_cell
// one table entry; shifts toward either neighbor or takes a write
// ----------------------------------------------------------------------------
module ffa_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  ffa_pkg::blk_t     init_i,
  input  ffa_pkg::cell_ctl_t ctl_i,
  input  logic              wr_sel_i,
  input  logic              sh_sel_i,
  input  ffa_pkg::blk_t     wr_blk_i,
  input  ffa_pkg::blk_t     lo_i,
  input  ffa_pkg::blk_t     hi_i,
  output ffa_pkg::blk_t     blk_o
);
  ffa_pkg::blk_t blk_q, blk_d;

  always_comb begin
    blk_d = blk_q;
    if (clear_i) begin
      blk_d = init_i;
    end else if (ctl_i.wr && wr_sel_i) begin
      blk_d = wr_blk_i;
    end else if (ctl_i.shift_dn && sh_sel_i) begin
      blk_d = hi_i;
    end else if (ctl_i.shift_up && sh_sel_i) begin
      blk_d = lo_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q <= '0;
    end else begin
      blk_q <= blk_d;
    end
  end

  assign blk_o = blk_q;
endmodule

// ----- tb/tb_first_fit_free_list_allocator_core.sv -----
// ----------------------------------------------------------------------------
// tb_first_fit_free_list_allocator_core
// self-checking bench for the first-fit free-list allocator
// ----------------------------------------------------------------------------
// a local copy of the free-block table predicts every response beat. the
// stimulus generator works from the live allocations that this copy hands
// out, so most frees return real blocks and fragment the table until it
// fills. a few phases change the region registers, each followed by a clear.
// both channels idle at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb_first_fit_free_list_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBlocks = ffa_pkg::MaxFreeBlocks;
  localparam int unsigned HdrBytes  = ffa_pkg::HeaderBytes;
  localparam longint unsigned SizeLimit = 64'd1 << ffa_pkg::SizeBits;
  localparam longint unsigned AddrSpan  = 64'd1 << 32;
  localparam int unsigned StallLimit = 3000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          req_valid = 1'b0;
  logic          req_ready;
  ffa_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  ffa_pkg::rsp_t rsp;
  logic          cfg_we = 1'b0;
  logic          cfg_idx = 1'b0;
  logic [31:0]   cfg_data = '0;

  always #10 clk_i = ~clk_i;

  first_fit_free_list_allocator_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // free-block table copy and region registers
  // ---------------------------------------------------------------------------
  longint unsigned tbl_start[NumBlocks];
  longint unsigned tbl_bytes[NumBlocks];
  int unsigned     tbl_cnt;
  logic [31:0]     reg_base = 32'd0;
  logic [24:0]     reg_size = 25'd16777216;

  typedef struct {
    logic [31:0] addr;
    logic [24:0] size;
    logic [12:0] adj;
  } grant_t;

  grant_t        live_q[$];     // blocks handed out and not yet returned
  ffa_pkg::req_t pend_q[$];     // beats waiting for the driver
  ffa_pkg::rsp_t rsp_exp_q[$];  // predicted responses in order

  int unsigned n_errors, n_alloc_ok, n_nofit, n_free, n_full, n_clear, n_rsp;
  bit burst_req, burst_rsp;

  // clear: one block over the region, size raised to 64, saturated and cut at the top
  function automatic void table_rebuild();
    longint unsigned sz, room;
    sz = reg_size;
    room = AddrSpan - reg_base;
    if (sz < 64) sz = 64;
    if (sz > SizeLimit) sz = SizeLimit;
    if (sz > room) sz = room;
    for (int i = 0; i < NumBlocks; i++) begin
      tbl_start[i] = 0;
      tbl_bytes[i] = 0;
    end
    tbl_start[0] = reg_base;
    tbl_bytes[0] = sz;
    tbl_cnt = 1;
  endfunction

  function automatic void table_remove(int unsigned k);
    if (k >= tbl_cnt) return;
    for (int unsigned i = k; i + 1 < tbl_cnt; i++) begin
      tbl_start[i] = tbl_start[i+1];
      tbl_bytes[i] = tbl_bytes[i+1];
    end
    tbl_cnt--;
    tbl_start[tbl_cnt] = 0;
    tbl_bytes[tbl_cnt] = 0;
  endfunction

  // first fit; header room always left ahead of the user address
  function automatic ffa_pkg::rsp_t first_fit(longint unsigned want, longint unsigned lg);
    ffa_pkg::rsp_t r;
    longint unsigned a, s, b, adj, total, need;
    r = '0;
    r.status = ffa_pkg::StNoFit;
    if (lg > 12) lg = 12;
    a = 64'd1 << lg;
    for (int unsigned i = 0; i < tbl_cnt; i++) begin
      s = tbl_start[i];
      b = tbl_bytes[i];
      adj = (AddrSpan - s) & (a - 1);
      if (adj < HdrBytes) begin
        need = HdrBytes - adj;
        adj += ((need + a - 1) >> lg) << lg;
      end
      total = want + adj;
      if (b < total) continue;
      if (b - total <= HdrBytes) begin
        total = b;
        table_remove(i);
      end else begin
        tbl_start[i] = s + total;
        tbl_bytes[i] = b - total;
      end
      r.status = ffa_pkg::StDone;
      r.user_address = 32'(s + adj);   // address at the very top wraps to zero
      r.granted_size = 25'(total);
      r.granted_adjust = 13'(adj);
      return r;
    end
    return r;
  endfunction

  // address-ordered return with merge into touching neighbours
  function automatic logic [1:0] return_block(longint unsigned addr, longint unsigned size,
                                              longint unsigned adj);
    longint unsigned bs, fin, merged;
    int unsigned k;
    bit mp, mn;
    mp = 0;
    mn = 0;
    if (size > SizeLimit) size = SizeLimit;
    if (size == 0 || adj > addr) return ffa_pkg::StDone;
    bs = addr - adj;
    fin = bs + size;
    if (fin > AddrSpan) return ffa_pkg::StDone;
    k = 0;
    while (k < tbl_cnt && tbl_start[k] < fin) k++;
    if (k > 0)
      mp = (tbl_start[k-1] + tbl_bytes[k-1] == bs) && (tbl_bytes[k-1] + size <= SizeLimit);
    if (k < tbl_cnt && tbl_start[k] == fin) begin
      merged = size + tbl_bytes[k];
      if (mp) merged += tbl_bytes[k-1];
      mn = merged <= SizeLimit;
    end
    if (mp && mn) begin
      tbl_bytes[k-1] += size + tbl_bytes[k];
      table_remove(k);
    end else if (mp) begin
      tbl_bytes[k-1] += size;
    end else if (mn) begin
      tbl_start[k] = bs;
      tbl_bytes[k] += size;
    end else begin
      if (tbl_cnt >= NumBlocks) return ffa_pkg::StFull;
      for (int unsigned i = tbl_cnt; i > k; i--) begin
        tbl_start[i] = tbl_start[i-1];
        tbl_bytes[i] = tbl_bytes[i-1];
      end
      tbl_start[k] = bs;
      tbl_bytes[k] = size;
      tbl_cnt++;
    end
    return ffa_pkg::StDone;
  endfunction

  // one accepted command beat -> one expected response beat
  function automatic void predict_beat(ffa_pkg::req_t q);
    ffa_pkg::rsp_t r;
    grant_t g;
    r = '0;
    case (q.cmd)
      ffa_pkg::CmdAlloc: begin
        r = first_fit(q.req_size, q.align_log2);
        if (r.status == ffa_pkg::StDone) begin
          n_alloc_ok++;
          g.addr = r.user_address;
          g.size = r.granted_size;
          g.adj  = r.granted_adjust;
          live_q.push_back(g);
        end else begin
          n_nofit++;
        end
      end
      ffa_pkg::CmdFree: begin
        r.status = return_block(q.address, q.freed_size, q.freed_adjust);
        n_free++;
        if (r.status == ffa_pkg::StFull) n_full++;
      end
      ffa_pkg::CmdClear: begin
        table_rebuild();
        n_clear++;
      end
      default: ;  // unknown command leaves everything alone
    endcase
    rsp_exp_q.push_back(r);
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s got 0x%0h want 0x%0h", $time, field, got, want);
    n_errors++;
  endtask

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one beat at a time from pend_q, random gap before each
  // ---------------------------------------------------------------------------
  int unsigned req_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else begin
      if (req_valid && req_ready) predict_beat(req);
      if (!req_valid || req_ready) begin
        if (req_gap > 0) begin
          req_gap   <= req_gap - 1;
          req_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          req       <= pend_q.pop_front();
          req_valid <= 1'b1;
          req_gap   <= draw_gap(burst_req);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall per response beat, field-by-field compare
  // ---------------------------------------------------------------------------
  int unsigned rsp_stall;

  always @(posedge clk_i or negedge rst_ni) begin
    ffa_pkg::rsp_t want;
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
      rsp_stall <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        n_rsp++;
        if (rsp_exp_q.size() == 0) begin
          $display("[%0t] response beat with nothing expected", $time);
          n_errors++;
        end else begin
          want = rsp_exp_q.pop_front();
          if (rsp.status !== want.status) report("status", rsp.status, want.status);
          if (rsp.user_address !== want.user_address)
            report("user_address", rsp.user_address, want.user_address);
          if (rsp.granted_size !== want.granted_size)
            report("granted_size", rsp.granted_size, want.granted_size);
          if (rsp.granted_adjust !== want.granted_adjust)
            report("granted_adjust", rsp.granted_adjust, want.granted_adjust);
        end
        rsp_stall <= draw_gap(burst_rsp);
        rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall <= rsp_stall - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles without any accepted beat
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("first_fit_free_list_allocator_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic ffa_pkg::req_t mk_alloc(logic [24:0] sz, logic [3:0] lg);
    ffa_pkg::req_t q;
    q = '0;
    q.cmd = ffa_pkg::CmdAlloc;
    q.req_size = sz;
    q.align_log2 = lg;
    return q;
  endfunction

  function automatic ffa_pkg::req_t mk_free(logic [31:0] addr, logic [24:0] sz,
                                            logic [12:0] adj);
    ffa_pkg::req_t q;
    q = '0;
    q.cmd = ffa_pkg::CmdFree;
    q.address = addr;
    q.freed_size = sz;
    q.freed_adjust = adj;
    return q;
  endfunction

  function automatic ffa_pkg::req_t mk_cmd(logic [1:0] c);
    ffa_pkg::req_t q;
    q = '0;
    q.cmd = c;
    return q;
  endfunction

  // push one beat and hold until the driver has it and its effect is known
  task automatic send(ffa_pkg::req_t q);
    pend_q.push_back(q);
    do @(posedge clk_i); while (pend_q.size() > 0 || req_valid);
  endtask

  // everything answered, block quiet, then registers, then a clear
  task automatic set_region(logic [31:0] base, logic [24:0] size);
    while (pend_q.size() > 0 || req_valid || rsp_exp_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= ffa_pkg::CfgBase;
    cfg_data <= base;
    reg_base = base;
    @(posedge clk_i);
    cfg_idx <= ffa_pkg::CfgSize;
    cfg_data <= 32'(size);
    reg_size = size;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    live_q.delete();
    send(mk_cmd(ffa_pkg::CmdClear));
  endtask

  // mostly well-formed alloc/free traffic, some noise
  task automatic random_phase(int unsigned count);
    ffa_pkg::req_t q;
    int unsigned pick, idx;
    logic [24:0] sz;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        burst_req = ($urandom_range(0, 3) == 0);
        burst_rsp = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35 && live_q.size() > 0) begin
        idx = $urandom_range(0, live_q.size() - 1);
        q = mk_free(live_q[idx].addr, live_q[idx].size, live_q[idx].adj);
        live_q.delete(idx);
      end else if (pick < 82) begin
        case ($urandom_range(0, 19))
          0:       sz = 25'd0;
          1:       sz = 25'($urandom);
          2, 3, 4: sz = 25'($urandom_range(257, 65536));
          default: sz = 25'($urandom_range(1, 256));
        endcase
        q = mk_alloc(sz, 4'($urandom_range(0, 15)));
      end else if (pick < 90) begin
        q = mk_free($urandom, 25'($urandom), 13'($urandom));
        if ($urandom_range(0, 1)) q.freed_size = 25'($urandom_range(0, 512));
        if ($urandom_range(0, 1)) q.freed_adjust = 13'($urandom_range(0, 64));
      end else if (pick < 93) begin
        q = mk_cmd(ffa_pkg::CmdClear);
        live_q.delete();
      end else if (pick < 95) begin
        q = ffa_pkg::req_t'($bits(ffa_pkg::req_t)'({$urandom, $urandom, $urandom,
                                                    $urandom}));
        q.cmd = ffa_pkg::CmdUnused;  // unknown command, other fields random
      end else begin
        q = mk_free($urandom, 25'($urandom_range(1, 4096)), 13'($urandom_range(0, 8191)));
      end
      send(q);
    end
  endtask

  initial begin
    table_rebuild();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes and the corner cases on the reset region
    send(mk_alloc(25'd0, 4'd0));
    send(mk_alloc(25'd100, 4'd15));           // alignment clipped to 4 KiB
    send(mk_alloc(25'd16777216, 4'd0));       // whole region plus header: no fit
    send(mk_alloc(25'h1FF_FFFF, 4'd12));
    send(mk_free(32'h0000_1000, 25'd0, 13'd0));                 // zero size ignored
    send(mk_free(32'hFFFF_FFFF, 25'h1FF_FFFF, 13'h1FFF));       // saturated, past top
    send(mk_free(32'd10, 25'd16, 13'd11));                      // adjust above address
    send(mk_free(live_q[0].addr, live_q[0].size, live_q[0].adj));
    send(mk_free(live_q[1].addr, live_q[1].size, live_q[1].adj)); // merges both sides
    send(mk_cmd(ffa_pkg::CmdUnused));
    send(mk_cmd(ffa_pkg::CmdClear));
    send(mk_free(32'd16777216, 25'd16, 13'd0)); // touching but merge too large
    for (int i = 0; i < 17; i++)                // fragments until the table is full
      send(mk_free(32'h0200_0000 + 32'(i) * 64, 25'd16, 13'd0));
    send(mk_cmd(ffa_pkg::CmdClear));
    live_q.delete();

    // region ending at the top of the address space: user address wraps
    set_region(32'hFFFF_FFF0, 25'd64);
    send(mk_alloc(25'd0, 4'd4));
    send(mk_alloc(25'd0, 4'd0));

    random_phase(150);
    set_region(32'd0, 25'd64);                  // smallest region
    random_phase(100);
    set_region(32'h1000_0000, 25'h1FF_FFFF);    // size saturated
    random_phase(150);
    set_region($urandom, 25'($urandom_range(0, 4096)));
    random_phase(100);
    set_region(32'hFF00_0000, 25'd16777216);    // region ends exactly at the top
    random_phase(100);
    set_region(32'hFFFF_FFFF, 25'd0);
    random_phase(20);
    set_region(32'h0000_0040, 25'd16777216);
    random_phase(100);

    while (pend_q.size() > 0 || req_valid || rsp_exp_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d responses: %0d grants, %0d no-fit, %0d frees (%0d refused full)",
             n_rsp, n_alloc_ok, n_nofit, n_free, n_full);
    $display("%0d clears over 7 region settings, %0d field mismatches", n_clear, n_errors);
    if (n_errors == 0) begin
      $display("first_fit_free_list_allocator_core: match");
    end else begin
      $display("first_fit_free_list_allocator_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ffa_pkg.sv
rtl/ffa_cell.sv
rtl/first_fit_free_list_allocator_core.sv
tb/tb_first_fit_free_list_allocator_core.sv
